// ----- hdl/quantized_keyframe_track_sampler_assert.svh -----
// Assertion macros shared by the keyframe sampler RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef QUANTIZED_KEYFRAME_TRACK_SAMPLER_ASSERT_SVH
`define QUANTIZED_KEYFRAME_TRACK_SAMPLER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define QKTS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qkts assertion failed");
// next-cycle implication
`define QKTS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qkts assertion failed");
`else
`define QKTS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define QKTS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/qkts_pkg.sv -----
// Shared constants, register indexes and structs of the keyframe sampler.
// No dependencies.
package qkts_pkg;

   localparam int TIME_BITS      = 31;                   // clamped, non-negative time
   localparam int FRAC_BITS      = 16;
   localparam int DIV_BITS       = TIME_BITS + FRAC_BITS; // quotient and divider depth
   localparam int PERIOD_W       = 32;
   localparam int VALUE_W        = 32;
   localparam int QUEUE_DEPTH    = 4;                    // power of two
   localparam int DEF_MAX_FRAMES = 256;
   localparam int REQ_DATA_W     = 48;
   localparam int RSP_DATA_W     = 112;
   localparam int CSR_IDX_W      = 2;

   localparam logic CMD_SAMPLE = 1'b1;                   // 0 is a store load

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_FRAME   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_VALUE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_VALUE   = 2'd3;

   localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RESET = 32'h0001_0000;

   typedef struct packed {
      logic [PERIOD_W-1:0] frame_period;  // never zero
      logic [7:0]          last_frame;
      logic [VALUE_W-1:0]  low_value;
      logic [VALUE_W-1:0]  high_value;
   } cfg_type;

   typedef struct packed {
      logic query;
      logic [7:0] idx;
      logic [7:0] val;
   } meta_type;

   typedef struct packed {
      meta_type             meta;
      logic [TIME_BITS-1:0] time_q;
   } item_type;

   typedef struct packed {
      logic                valid;
      meta_type            meta;
      logic [DIV_BITS-1:0] pos;
   } div_out_type;

endpackage

// ----- hdl/qkts_front.sv -----
// Front end: takes request beats, decodes the command and clamps the time.
// Uses qkts_pkg; feeds qkts_queue.
module qkts_front import qkts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample_index, sample_value, sample_time
   input  logic                  req_tuser,   // command
   input  logic                  q_full,
   output logic                  push,
   output item_type              push_item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     accept;

   assign push       = valid_ff && !q_full;
   assign req_tready = !valid_ff || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign push_item  = item_ff;

   always_comb begin
      item_in.meta.query = (req_tuser == CMD_SAMPLE);
      item_in.meta.idx   = req_tdata[7:0];
      item_in.meta.val   = req_tdata[15:8];
      // negative time clamps to zero
      item_in.time_q     = req_tdata[47] ? '0 : req_tdata[46:16];
      valid_in           = accept ? 1'b1 : (push ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- hdl/qkts_queue.sv -----
// Short FIFO between the front end and the back pipeline.
// Uses qkts_pkg; register slots, combinational head.
module qkts_queue import qkts_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output item_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hdl/qkts_div.sv -----
// Pipelined restoring divider: (time << 16) / frame_period, one quotient bit per stage.
// Uses qkts_pkg; item metadata rides along so loads stay in order with queries.
module qkts_div import qkts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  item_type            in_item,
   input  logic [PERIOD_W-1:0] divisor,
   output div_out_type         dout
);

   logic [DIV_BITS-1:0] valid_ff;
   meta_type            meta_ff [DIV_BITS];
   logic [PERIOD_W-1:0] rem_ff  [DIV_BITS];
   logic [DIV_BITS-1:0] nq_ff   [DIV_BITS];   // dividend bits left, quotient bits in

   logic [PERIOD_W-1:0] rem_src [DIV_BITS];
   logic [DIV_BITS-1:0] nq_src  [DIV_BITS];
   logic [PERIOD_W-1:0] rem_in  [DIV_BITS];
   logic [DIV_BITS-1:0] nq_in   [DIV_BITS];

   always_comb begin
      logic [PERIOD_W:0]   ext;
      logic [PERIOD_W+1:0] trial;
      rem_src[0] = '0;
      nq_src[0]  = {in_item.time_q, {FRAC_BITS{1'b0}}};
      for (int k = 1; k < DIV_BITS; k++) begin
         rem_src[k] = rem_ff[k-1];
         nq_src[k]  = nq_ff[k-1];
      end
      for (int k = 0; k < DIV_BITS; k++) begin
         ext   = {rem_src[k], nq_src[k][DIV_BITS-1]};
         trial = {1'b0, ext} - {2'b00, divisor};
         // remainder stays below the divisor, so 32 bits hold it
         rem_in[k] = trial[PERIOD_W+1] ? ext[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         nq_in[k]  = {nq_src[k][DIV_BITS-2:0], ~trial[PERIOD_W+1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DIV_BITS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0] <= in_item.meta;
         for (int k = 1; k < DIV_BITS; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
         for (int k = 0; k < DIV_BITS; k++) begin
            rem_ff[k] <= rem_in[k];
            nq_ff[k]  <= nq_in[k];
         end
      end
   end

   assign dout.valid = valid_ff[DIV_BITS-1];
   assign dout.meta  = meta_ff[DIV_BITS-1];
   assign dout.pos   = nq_ff[DIV_BITS-1];

endmodule

// ----- hdl/qkts_back.sv -----
// Back pipeline: frame clamp, sample store, dequantize, interpolate, output register.
// Uses qkts_pkg and the assertion macro header.
`include "quantized_keyframe_track_sampler_assert.svh"
module qkts_back import qkts_pkg::*; #(
   parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  div_out_type           din,
   output logic                  adv,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // lower, upper, fraction, weight
);

   localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

   logic [7:0] store_mem [MAX_FRAMES];

   // frame clamp
   logic [31:0] last32, lim32, last_eff, ia32, ia_sel, ib_sel, idx32;
   logic        past_end, at_end, idx_ok;

   // stage registers
   logic                  r1_valid_ff, r2_valid_ff, r3_valid_ff, r4_valid_ff, r5_valid_ff;
   logic                  out_valid_ff;
   logic [7:0]            byte_a_ff, byte_b_ff;
   logic [FRAC_BITS-1:0]  r1_frac_ff, r2_frac_ff, r3_frac_ff, r4_frac_ff, r5_frac_ff;
   logic signed [41:0]    prod_a_ff, prod_b_ff;
   logic signed [31:0]    va_ff, vb_ff, r4_va_ff, r4_vb_ff, r5_va_ff, r5_vb_ff;
   logic signed [32:0]    diff_ff;
   logic signed [49:0]    mix_ff;
   logic signed [31:0]    lower_ff, upper_ff, weight_ff;
   logic [FRAC_BITS-1:0]  frac_ff;

   // combinational arithmetic
   logic signed [32:0]    range_s;
   logic signed [41:0]    prod_a_in, prod_b_in;
   logic signed [33:0]    sum_a, sum_b, w_sum;
   logic signed [32:0]    diff_in;
   logic signed [49:0]    mix_in;

   assign adv = !out_valid_ff || rsp_tready;

   always_comb begin
      last32   = {24'd0, cfg.last_frame};
      lim32    = 32'(MAX_FRAMES - 1);
      last_eff = (last32 > lim32) ? lim32 : last32;
      ia32     = {1'b0, din.pos[DIV_BITS-1:FRAC_BITS]};
      past_end = (ia32 > last_eff);
      at_end   = (ia32 >= last_eff);       // successor past the end
      ia_sel   = past_end ? last_eff : ia32;
      ib_sel   = at_end ? last_eff : 32'(ia32 + 32'd1);
      idx32    = {24'd0, din.meta.idx};
      idx_ok   = (idx32 < 32'(MAX_FRAMES));
   end

   // store: loads write and queries read at the same point, so order holds
   always_ff @(posedge clock) begin
      if (adv && din.valid) begin
         if (din.meta.query) begin
            byte_a_ff <= store_mem[ADDR_W'(ia_sel)];
            byte_b_ff <= store_mem[ADDR_W'(ib_sel)];
         end else if (idx_ok) begin
            store_mem[ADDR_W'(din.meta.idx)] <= din.meta.val;
         end
      end
   end

   always_comb begin
      range_s   = $signed({cfg.high_value[31], cfg.high_value})
                - $signed({cfg.low_value[31], cfg.low_value});
      prod_a_in = range_s * $signed({1'b0, byte_a_ff});
      prod_b_in = range_s * $signed({1'b0, byte_b_ff});
      // arithmetic drop of 8 bits is floor toward minus infinity
      sum_a     = $signed({{2{cfg.low_value[31]}}, cfg.low_value}) + $signed(prod_a_ff[41:8]);
      sum_b     = $signed({{2{cfg.low_value[31]}}, cfg.low_value}) + $signed(prod_b_ff[41:8]);
      diff_in   = $signed({vb_ff[31], vb_ff}) - $signed({va_ff[31], va_ff});
      mix_in    = diff_ff * $signed({1'b0, r4_frac_ff});
      w_sum     = $signed({{2{r5_va_ff[31]}}, r5_va_ff}) + $signed(mix_ff[49:16]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff  <= 1'b0;
         r2_valid_ff  <= 1'b0;
         r3_valid_ff  <= 1'b0;
         r4_valid_ff  <= 1'b0;
         r5_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         r1_valid_ff  <= din.valid && din.meta.query;
         r2_valid_ff  <= r1_valid_ff;
         r3_valid_ff  <= r2_valid_ff;
         r4_valid_ff  <= r3_valid_ff;
         r5_valid_ff  <= r4_valid_ff;
         out_valid_ff <= r5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r1_frac_ff <= at_end ? '0 : din.pos[FRAC_BITS-1:0];
         prod_a_ff  <= prod_a_in;
         prod_b_ff  <= prod_b_in;
         r2_frac_ff <= r1_frac_ff;
         va_ff      <= sum_a[31:0];
         vb_ff      <= sum_b[31:0];
         r3_frac_ff <= r2_frac_ff;
         diff_ff    <= diff_in;
         r4_va_ff   <= va_ff;
         r4_vb_ff   <= vb_ff;
         r4_frac_ff <= r3_frac_ff;
         mix_ff     <= mix_in;
         r5_va_ff   <= r4_va_ff;
         r5_vb_ff   <= r4_vb_ff;
         r5_frac_ff <= r4_frac_ff;
         lower_ff   <= r5_va_ff;
         upper_ff   <= r5_vb_ff;
         frac_ff    <= r5_frac_ff;
         weight_ff  <= w_sum[31:0];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {weight_ff, frac_ff, upper_ff, lower_ff};

   `QKTS_ASSERT_IMP(a_weight_in_span, clock, reset, out_valid_ff, ((weight_ff >= lower_ff) && (weight_ff <= upper_ff)) || ((weight_ff <= lower_ff) && (weight_ff >= upper_ff)))
   `QKTS_ASSERT_NXT(a_clamp_zero_frac, clock, reset, adv && at_end, r1_frac_ff == '0)
   `QKTS_ASSERT_IMP(a_index_pair, clock, reset, din.valid && din.meta.query, (ib_sel <= last_eff) && ((ib_sel == ia_sel) || (ib_sel == 32'(ia_sel + 32'd1))))

endmodule

// ----- hdl/quantized_keyframe_track_sampler.sv -----
// Quantized keyframe track sampler: config registers, front end, queue, divider, back pipeline.
// A sample req beat passes the front register, the queue, the divider and the back pipeline,
//    in that order. Throughput: one beat per cycle while no rsp beat is stalled.
// A stalled rsp beat freezes the divider and the back; the queue and front register absorb
//    five more req beats before req_tready drops.
// Reset: synchronous, active high; clears valids and the queue, loads register defaults.
module quantized_keyframe_track_sampler import qkts_pkg::*; #(
   parameter int MAX_FRAMES = DEF_MAX_FRAMES   // store depth, 2 to 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] sample_index, [15:8] sample_value,
                                              // [47:16] sample_time
   input  logic                  req_tuser,   // [0] command: 0 load, 1 sample
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] lower_value, [63:32] upper_value,
                                              // [79:64] fraction, [111:80] weight
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]           csr_wdata
);

   // The sample store is not cleared at reset and no clearing pass runs.

   cfg_type     cfg_ff;
   logic        q_full, q_not_empty, push, adv;
   item_type    push_item, head;
   div_out_type div_out;

   // Register file. A zero frame period is stored as one so the divider never sees zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_period <= FRAME_PERIOD_RESET;
         cfg_ff.last_frame   <= '0;
         cfg_ff.low_value    <= '0;
         cfg_ff.high_value   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_PERIOD: begin
               cfg_ff.frame_period <= (csr_wdata == '0) ? 32'd1 : csr_wdata;
            end
            CSR_LAST_FRAME: begin
               cfg_ff.last_frame <= csr_wdata[7:0];
            end
            CSR_LOW_VALUE: begin
               cfg_ff.low_value <= csr_wdata;
            end
            CSR_HIGH_VALUE: begin
               cfg_ff.high_value <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // front end: one input register, decode and time clamp
   qkts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   // decoupling queue; popped whenever the back pipeline advances
   qkts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (adv && q_not_empty),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   // frame position; loads pass through untouched to keep order with queries
   qkts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (q_not_empty),
      .in_item  (head),
      .divisor  (cfg_ff.frame_period),
      .dout     (div_out)
   );

   // clamp, store access, dequantize, interpolate, output register
   qkts_back #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .din        (div_out),
      .adv        (adv),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
